// ===== design/base64_stream_decoder_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Base64 stream decoder assertion macros
// Shared concurrent assertion wrappers, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_DECODER_UNIT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define B64D_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define B64D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/b64d_pkg.sv =====
// ---------------------------------------------------------------------------
// Base64 stream decoder package
// Request types, character constants and the character-to-sextet lookup.
// ---------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned SextetW = 6;
  localparam int unsigned GroupW  = 2;
  localparam int unsigned NumHeld = 3;
  localparam int unsigned MaxRes  = 3;
  localparam int unsigned CntW    = 2;

  localparam logic [CharW-1:0] CharUpperA = 8'h41;
  localparam logic [CharW-1:0] CharUpperZ = 8'h5A;
  localparam logic [CharW-1:0] CharLowerA = 8'h61;
  localparam logic [CharW-1:0] CharLowerZ = 8'h7A;
  localparam logic [CharW-1:0] CharDigit0 = 8'h30;
  localparam logic [CharW-1:0] CharDigit9 = 8'h39;
  localparam logic [CharW-1:0] CharPlus   = 8'h2B;
  localparam logic [CharW-1:0] CharSlash  = 8'h2F;
  localparam logic [CharW-1:0] CharPad    = 8'h3D;

  localparam logic [SextetW-1:0] LowerBase = 6'd26;
  localparam logic [SextetW-1:0] DigitBase = 6'd52;
  localparam logic [SextetW-1:0] PlusCode  = 6'd62;
  localparam logic [SextetW-1:0] SlashCode = 6'd63;

  localparam logic [GroupW-1:0] PosThird  = 2'd2;
  localparam logic [GroupW-1:0] PosFourth = 2'd3;

  typedef struct packed {
    logic [CharW-1:0] char_in;
    logic             end_of_stream;
  } b64d_in_t;

  typedef struct packed {
    logic [CharW-1:0] data_byte;
    logic             byte_valid;
    logic             last_of_group;
    logic             stream_done;
  } b64d_out_t;

  typedef struct packed {
    logic               bad;
    logic [SextetW-1:0] value;
  } b64d_sextet_t;

  // Map one character to its sextet; flag anything outside the alphabet.
  function automatic b64d_sextet_t sextet_of(input logic [CharW-1:0] ch);
    b64d_sextet_t r;
    logic [CharW-1:0] diff;
    r    = '{bad: 1'b0, value: '0};
    diff = '0;
    if (ch >= CharUpperA && ch <= CharUpperZ) begin
      diff    = ch - CharUpperA;
      r.value = diff[SextetW-1:0];
    end else if (ch >= CharLowerA && ch <= CharLowerZ) begin
      diff    = ch - CharLowerA;
      r.value = diff[SextetW-1:0] + LowerBase;
    end else if (ch >= CharDigit0 && ch <= CharDigit9) begin
      diff    = ch - CharDigit0;
      r.value = diff[SextetW-1:0] + DigitBase;
    end else if (ch == CharPlus) begin
      r.value = PlusCode;
    end else if (ch == CharSlash) begin
      r.value = SlashCode;
    end else if (ch == CharPad) begin
      r.value = '0;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/base64_stream_decoder_unit.sv =====
// ---------------------------------------------------------------------------
// Base64 stream decoder
// Decodes one ASCII character per request into a stream of decoded bytes.
// ---------------------------------------------------------------------------
// One character request is taken per clock cycle. The first three characters
// of a group only update the group registers and return nothing. The fourth
// character (or a character flagged end_of_stream) loads a result burst of
// one to three entries into the result register, which drains one entry per
// cycle unless the output stalls; a valid group gives its bytes, a group with
// any character outside the Base64 alphabet gives none, and an end of stream
// that yields no byte gives a single empty marker (byte_valid low). The input
// keeps accepting characters that produce no result while a burst drains, so
// a well-formed stream runs at one character per cycle. The only input stall
// comes from the single result burst register: a burst-producing character
// waits while the previous burst still has more than its final entry left,
// or while the output side stalls. A partial group at end of stream is
// dropped, and the next request then starts a fresh message.
// ---------------------------------------------------------------------------
`default_nettype none

`include "base64_stream_decoder_unit_defines.svh"

module base64_stream_decoder_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire b64d_pkg::b64d_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output b64d_pkg::b64d_out_t      out_data_o
);

  import b64d_pkg::*;

  // Group state
  logic [GroupW-1:0]  pos_q, pos_d;
  logic [SextetW-1:0] held_q [NumHeld];
  logic [SextetW-1:0] held_d [NumHeld];
  logic               inv_q, inv_d;
  logic               tpad_q, tpad_d;

  // Result burst register: entries shift toward slot 0 as they are taken
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CharW-1:0]   res_q [MaxRes];
  logic [CharW-1:0]   res_d [MaxRes];
  logic               mark_q, mark_d;
  logic               eos_q, eos_d;

  // Decode of the incoming character
  b64d_sextet_t       sx;
  logic               is_pad;
  logic               fourth;
  logic               good4;
  logic               emit;
  logic [CharW-1:0]   byte0, byte1, byte2;
  logic [CntW-1:0]    new_cnt;

  // Handshake
  logic               busy;
  logic               out_take;
  logic               freeing;
  logic               in_acc;

  assign sx     = sextet_of(in_data_i.char_in);
  assign is_pad = (in_data_i.char_in == CharPad);
  assign fourth = (pos_q == PosFourth);
  assign good4  = fourth && !inv_q && !sx.bad;
  // A request loads a burst when it closes a clean group or ends the message.
  assign emit   = good4 || in_data_i.end_of_stream;

  // Reassemble three bytes from four sextets.
  assign byte0 = {held_q[0], held_q[1][5:4]};
  assign byte1 = {held_q[1][3:0], held_q[2][5:2]};
  assign byte2 = {held_q[2][1:0], sx.value};

  always_comb begin
    new_cnt = CntW'(1);
    if (good4) begin
      new_cnt = CntW'(1) + CntW'(!tpad_q) + CntW'(!is_pad);
    end
  end

  assign busy       = (cnt_q != '0);
  assign out_take   = busy && !out_stall_i;
  assign freeing    = out_take && (cnt_q == CntW'(1));
  // Hold a burst-producing request until the burst register is free.
  assign in_stall_o = busy && !freeing && emit;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Group state update
  always_comb begin
    pos_d  = pos_q;
    inv_d  = inv_q;
    tpad_d = tpad_q;
    for (int i = 0; i < NumHeld; i++) begin
      held_d[i] = held_q[i];
    end
    if (in_acc) begin
      if (fourth || in_data_i.end_of_stream) begin
        // Close the group: either decoded or dropped.
        pos_d  = '0;
        inv_d  = 1'b0;
        tpad_d = 1'b0;
      end else begin
        for (int i = 0; i < NumHeld; i++) begin
          if (pos_q == GroupW'(i)) begin
            held_d[i] = sx.bad ? '0 : sx.value;
          end
        end
        inv_d = inv_q | sx.bad;
        if (pos_q == PosThird) begin
          tpad_d = is_pad;
        end
        pos_d = pos_q + GroupW'(1);
      end
    end
  end

  // Burst register update
  always_comb begin
    cnt_d  = cnt_q;
    mark_d = mark_q;
    eos_d  = eos_q;
    for (int i = 0; i < MaxRes; i++) begin
      res_d[i] = res_q[i];
    end
    if (in_acc && emit) begin
      // Load a compacted burst; a padded third character drops byte one.
      cnt_d    = new_cnt;
      mark_d   = !good4;
      eos_d    = in_data_i.end_of_stream;
      res_d[0] = good4 ? byte0 : '0;
      res_d[1] = tpad_q ? byte2 : byte1;
      res_d[2] = byte2;
    end else if (out_take) begin
      // Advance to the next entry.
      cnt_d = cnt_q - CntW'(1);
      for (int i = 0; i < MaxRes - 1; i++) begin
        res_d[i] = res_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      inv_q  <= 1'b0;
      tpad_q <= 1'b0;
      cnt_q  <= '0;
      mark_q <= 1'b0;
      eos_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      inv_q  <= inv_d;
      tpad_q <= tpad_d;
      cnt_q  <= cnt_d;
      mark_q <= mark_d;
      eos_q  <= eos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumHeld; i++) begin
      held_q[i] <= held_d[i];
    end
    for (int i = 0; i < MaxRes; i++) begin
      res_q[i] <= res_d[i];
    end
  end

  assign out_valid_o              = busy;
  assign out_data_o.data_byte     = res_q[0];
  assign out_data_o.byte_valid    = !mark_q;
  assign out_data_o.last_of_group = (cnt_q == CntW'(1));
  assign out_data_o.stream_done   = (cnt_q == CntW'(1)) && eos_q;

  // A request taken while an unfinished burst drains must produce no result.
  `B64D_ASSERT_SAME(a_no_overrun, clk_i, rst_ni,
    in_acc && busy && !freeing, !emit, "burst register overrun")
  // Stream end only on the last entry of a burst.
  `B64D_ASSERT_SAME(a_done_is_last, clk_i, rst_ni,
    out_valid_o && out_data_o.stream_done, out_data_o.last_of_group,
    "stream_done without last_of_group")
  // An empty marker is a lone end-of-stream entry carrying zero.
  `B64D_ASSERT_SAME(a_marker_shape, clk_i, rst_ni,
    out_valid_o && !out_data_o.byte_valid,
    out_data_o.stream_done && (out_data_o.data_byte == '0),
    "malformed end marker")
  // End of stream restarts group tracking.
  `B64D_ASSERT_NEXT(a_eos_clears, clk_i, rst_ni,
    in_acc && in_data_i.end_of_stream, (pos_q == '0) && !inv_q && !tpad_q,
    "group state not cleared at end of stream")

endmodule

`default_nettype wire
